// ===== sv/imac_pkg.sv =====
// imac_pkg: shared constants, tables, types and functions of the merkle accumulator
// used by every file of the block but imac_ram; depends on nothing

package imac_pkg;

   localparam int MaxLeaves  = 1024;
   localparam int LevelCount = 11;
   localparam int Capacity   = (MaxLeaves < (1 << (LevelCount - 1))) ?
                               MaxLeaves : (1 << (LevelCount - 1));
   localparam int CountW     = $clog2(Capacity + 1);
   localparam int PosW       = $clog2(Capacity);
   localparam int LvW        = $clog2(LevelCount);
   localparam int ModeW      = 2;
   localparam int IdxW       = 10;
   localparam int StatusW    = 2;
   localparam int WordW      = 64;
   localparam int HashW      = 256;
   localparam int BlockW     = 512;
   localparam int OffW       = 17;
   localparam logic [OffW-1:0] OffLimit = OffW'(32'h0000_FFFF);

   function automatic int level_size(input int lv);
      return ((Capacity - 1) >> lv) + 1;
   endfunction

   function automatic int node_total();
      int sum;
      sum = 0;
      for (int k = 0; k < LevelCount; k++) sum += level_size(k);
      return sum;
   endfunction

   localparam int NodeCount = node_total();
   localparam int AddrW     = $clog2(NodeCount);

   typedef logic [AddrW-1:0] base_tbl_type [LevelCount];

   function automatic base_tbl_type calc_base();
      base_tbl_type tbl;
      int sum;
      sum = 0;
      for (int k = 0; k < LevelCount; k++) begin
         tbl[k] = AddrW'(sum);
         sum += level_size(k);
      end
      return tbl;
   endfunction

   localparam base_tbl_type LevelBase = calc_base();

   // request modes
   localparam logic [ModeW-1:0] MODE_APPEND = 2'd0;
   localparam logic [ModeW-1:0] MODE_VERIFY = 2'd1;
   localparam logic [ModeW-1:0] MODE_ROOT   = 2'd2;
   localparam logic [ModeW-1:0] MODE_NONE   = 2'd3;

   // response status codes
   localparam logic [StatusW-1:0] ST_OK       = 2'd0;
   localparam logic [StatusW-1:0] ST_BAD      = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL     = 2'd2;
   localparam logic [StatusW-1:0] ST_MISMATCH = 2'd3;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // padding block of a 64-byte message
   localparam logic [BlockW-1:0] PadBlock = {32'h8000_0000, 448'd0, 32'd512};

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SET_STATUS,
      OP_APPEND_LEAF,
      OP_INIT_VERIFY,
      OP_INIT_ROOT,
      OP_READ_LEFT,
      OP_READ_SELF,
      OP_READ_ROOT,
      OP_SRCH_READ,
      OP_SRCH_INIT,
      OP_SRCH_NEXT,
      OP_ADVANCE,
      OP_LEVEL_UP,
      OP_HASH_LR,
      OP_HASH_DR,
      OP_STORE_PARENT,
      OP_TAKE_HASH,
      OP_COMPARE,
      OP_TAKE_ROOT,
      OP_RSP_LOAD
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [StatusW-1:0]  status;
   } cmd_type;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic full;
      logic idx_bad;
      logic empty;
      logic order_zero;
      logic order_odd;
      logic lv_top;
      logic has_next;
      logic srch_hit;
      logic srch_stop;
      logic hash_done;
      logic rsp_busy;
   } flags_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

endpackage

// ===== sv/imac_req_if.sv =====
// imac_req_if: request channel of the merkle accumulator
// valid/ready handshake with the request fields; uses imac_pkg widths

interface imac_req_if;
   logic                          valid;
   logic                          ready;
   logic [imac_pkg::ModeW-1:0]    mode;
   logic [imac_pkg::WordW-1:0]    leaf_word0;
   logic [imac_pkg::WordW-1:0]    leaf_word1;
   logic [imac_pkg::WordW-1:0]    leaf_word2;
   logic [imac_pkg::WordW-1:0]    leaf_word3;
   logic [imac_pkg::IdxW-1:0]     leaf_index;

   modport source (output valid, mode, leaf_word0, leaf_word1, leaf_word2, leaf_word3,
                   leaf_index, input ready);
   modport sink (input valid, mode, leaf_word0, leaf_word1, leaf_word2, leaf_word3,
                 leaf_index, output ready);
endinterface

// ===== sv/imac_rsp_if.sv =====
// imac_rsp_if: response channel of the merkle accumulator
// valid/ready handshake with the response fields; uses imac_pkg widths

interface imac_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [imac_pkg::StatusW-1:0]  status;
   logic [imac_pkg::WordW-1:0]    root_word0;
   logic [imac_pkg::WordW-1:0]    root_word1;
   logic [imac_pkg::WordW-1:0]    root_word2;
   logic [imac_pkg::WordW-1:0]    root_word3;
   logic [imac_pkg::CountW-1:0]   leaf_count;

   modport source (output valid, status, root_word0, root_word1, root_word2, root_word3,
                   leaf_count, input ready);
   modport sink (input valid, status, root_word0, root_word1, root_word2, root_word3,
                 leaf_count, output ready);
endinterface

// ===== sv/imac_ram.sv =====
// imac_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module imac_ram #(
   parameter int Width = 256,
   parameter int Depth = 2048,
   localparam int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [Width-1:0] rdata
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/imac_hash.sv =====
// imac_hash: iterative node hash, sha256(d||d) with d = sha256(a||b)
// four compressions of 64 rounds, one round per cycle; uses imac_pkg

module imac_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [imac_pkg::BlockW-1:0]  msg,
   output logic                         busy,
   output logic                         done,
   output logic [imac_pkg::HashW-1:0]   digest
);

   typedef enum logic [3:0] {
      H_IDLE  = 4'b0001,
      H_LOAD  = 4'b0010,
      H_ROUND = 4'b0100,
      H_FIN   = 4'b1000
   } hstate_type;

   hstate_type  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  round_ff, round_in;
   logic        done_ff, done_in;
   logic [imac_pkg::BlockW-1:0] msg_ff, msg_in;
   logic [31:0] hv_ff [8];
   logic [31:0] hv_in [8];
   logic [31:0] wv_ff [8];
   logic [31:0] wv_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [imac_pkg::BlockW-1:0] block;
   logic [31:0] t1, t2, ws0, ws1, bs0, bs1, ch, maj;

   always_comb begin
      for (int i = 0; i < 8; i++) digest[imac_pkg::HashW-1-32*i -: 32] = hv_ff[i];
   end

   always_comb begin
      priority if (phase_ff[0]) block = imac_pkg::PadBlock;
      else if (phase_ff[1])     block = {digest, digest};
      else                      block = msg_ff;
   end

   always_comb begin
      bs1 = imac_pkg::rotr(wv_ff[4], 6) ^ imac_pkg::rotr(wv_ff[4], 11)
          ^ imac_pkg::rotr(wv_ff[4], 25);
      bs0 = imac_pkg::rotr(wv_ff[0], 2) ^ imac_pkg::rotr(wv_ff[0], 13)
          ^ imac_pkg::rotr(wv_ff[0], 22);
      ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1  = wv_ff[7] + bs1 + ch + imac_pkg::RoundK[round_ff] + win_ff[0];
      t2  = bs0 + maj;
      ws0 = imac_pkg::rotr(win_ff[1], 7) ^ imac_pkg::rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      ws1 = imac_pkg::rotr(win_ff[14], 17) ^ imac_pkg::rotr(win_ff[14], 19)
          ^ (win_ff[14] >> 10);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      done_in  = 1'b0;
      msg_in   = msg_ff;
      hv_in    = hv_ff;
      wv_in    = wv_ff;
      win_in   = win_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               msg_in   = msg;
               phase_in = 2'd0;
               state_in = H_LOAD;
            end
         end
         H_LOAD: begin
            for (int i = 0; i < 16; i++) win_in[i] = block[imac_pkg::BlockW-1-32*i -: 32];
            // first block of each message starts from the initial hash value
            if (!phase_ff[0]) begin
               hv_in = imac_pkg::InitHash;
               wv_in = imac_pkg::InitHash;
            end else begin
               wv_in = hv_ff;
            end
            round_in = '0;
            state_in = H_ROUND;
         end
         H_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
            win_in[15] = win_ff[0] + ws0 + win_ff[9] + ws1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = H_FIN;
         end
         H_FIN: begin
            for (int i = 0; i < 8; i++) hv_in[i] = hv_ff[i] + wv_ff[i];
            if (phase_ff == 2'd3) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               phase_in = phase_ff + 2'd1;
               state_in = H_LOAD;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      round_ff <= round_in;
      msg_ff   <= msg_in;
      hv_ff    <= hv_in;
      wv_ff    <= wv_in;
      win_ff   <= win_in;
   end

   assign busy = (state_ff != H_IDLE);
   assign done = done_ff;

endmodule

// ===== sv/imac_datapath.sv =====
// imac_datapath: node store, level fill counts, hash unit and response register
// driven by imac_ctrl commands; uses imac_pkg, imac_ram, imac_hash

module imac_datapath (
   input  logic                  clock,
   input  logic                  reset,
   imac_req_if.sink              req_ch,
   imac_rsp_if.source            rsp_ch,
   input  imac_pkg::cmd_type     cmd,
   output imac_pkg::flags_type   flags
);

   localparam int CountW = imac_pkg::CountW;
   localparam int PosW   = imac_pkg::PosW;
   localparam int LvW    = imac_pkg::LvW;
   localparam int AddrW  = imac_pkg::AddrW;
   localparam int OffW   = imac_pkg::OffW;
   localparam int HashW  = imac_pkg::HashW;
   localparam int LevelCount = imac_pkg::LevelCount;

   logic [imac_pkg::ModeW-1:0]   mode_ff, mode_in;
   logic [imac_pkg::IdxW-1:0]    idx_ff, idx_in;
   logic [HashW-1:0]             d_ff, d_in;
   logic [HashW-1:0]             root_ff, root_in;
   logic [imac_pkg::StatusW-1:0] status_ff, status_in;
   logic [CountW-1:0]            leaves_ff, leaves_in;
   logic [CountW-1:0]            fill_ff [LevelCount];
   logic [CountW-1:0]            fill_in [LevelCount];
   logic [PosW-1:0]              order_ff, order_in;
   logic [LvW-1:0]               lv_ff, lv_in;
   logic [LvW-1:0]               k_ff, k_in;
   logic [OffW-1:0]              off_ff, off_in;
   logic                         zero_ff, zero_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [imac_pkg::StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [HashW-1:0]             rsp_root_ff, rsp_root_in;
   logic [CountW-1:0]            rsp_count_ff, rsp_count_in;

   logic [LvW-1:0]    lv_up, k_dn, rd_lvl, wr_lvl;
   logic [PosW-1:0]   rd_pos, wr_pos;
   logic [CountW-1:0] fill_up, fill_k;
   logic              lv_top, rd_op;
   logic              ram_we;
   logic [AddrW-1:0]  ram_waddr, ram_raddr;
   logic [HashW-1:0]  ram_wdata, ram_rdata, other;
   logic              hash_start, hash_busy, hash_done;
   logic [imac_pkg::BlockW-1:0] hash_msg;
   logic [HashW-1:0]  hash_digest;

   assign lv_up   = lv_ff + LvW'(1);
   assign k_dn    = k_ff - LvW'(1);
   assign lv_top  = (lv_ff == LvW'(LevelCount - 1));
   assign fill_up = lv_top ? '0 : fill_ff[lv_up];
   assign fill_k  = fill_ff[k_dn];
   // a node past the fill count of its level reads as zero
   assign other   = zero_ff ? '0 : ram_rdata;

   always_comb begin
      rd_lvl = lv_ff;
      rd_pos = order_ff;
      rd_op  = 1'b0;
      unique case (cmd.op)
         imac_pkg::OP_READ_LEFT: begin
            rd_pos = order_ff - PosW'(1);
            rd_op  = 1'b1;
         end
         imac_pkg::OP_READ_SELF: rd_op = 1'b1;
         imac_pkg::OP_READ_ROOT: begin
            rd_pos = '0;
            rd_op  = 1'b1;
         end
         imac_pkg::OP_SRCH_READ: begin
            rd_lvl = k_dn;
            rd_pos = off_ff[PosW-1:0];
            rd_op  = 1'b1;
         end
         default: rd_op = 1'b0;
      endcase
   end

   assign ram_raddr = imac_pkg::LevelBase[rd_lvl] + AddrW'(rd_pos);

   always_comb begin
      wr_lvl    = '0;
      wr_pos    = leaves_ff[PosW-1:0];
      ram_wdata = d_ff;
      ram_we    = 1'b0;
      if (cmd.op == imac_pkg::OP_APPEND_LEAF) begin
         ram_we = 1'b1;
      end else if (cmd.op == imac_pkg::OP_STORE_PARENT) begin
         wr_lvl    = lv_up;
         wr_pos    = order_ff >> 1;
         ram_wdata = hash_digest;
         ram_we    = (CountW'(wr_pos) <= fill_up);
      end
   end

   assign ram_waddr  = imac_pkg::LevelBase[wr_lvl] + AddrW'(wr_pos);
   assign hash_start = (cmd.op == imac_pkg::OP_HASH_LR) || (cmd.op == imac_pkg::OP_HASH_DR);
   assign hash_msg   = (cmd.op == imac_pkg::OP_HASH_DR) ? {d_ff, other} : {other, d_ff};

   always_comb begin
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      d_in          = d_ff;
      root_in       = root_ff;
      status_in     = status_ff;
      leaves_in     = leaves_ff;
      fill_in       = fill_ff;
      order_in      = order_ff;
      lv_in         = lv_ff;
      k_in          = k_ff;
      off_in        = off_ff;
      zero_in       = zero_ff;
      rsp_status_in = rsp_status_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (rd_op) zero_in = (CountW'(rd_pos) >= fill_ff[rd_lvl]);
      unique case (cmd.op)
         imac_pkg::OP_CAPTURE: begin
            mode_in   = req_ch.mode;
            idx_in    = req_ch.leaf_index;
            d_in      = {req_ch.leaf_word0, req_ch.leaf_word1,
                         req_ch.leaf_word2, req_ch.leaf_word3};
            status_in = imac_pkg::ST_OK;
            root_in   = '0;
         end
         imac_pkg::OP_SET_STATUS: status_in = cmd.status;
         imac_pkg::OP_APPEND_LEAF: begin
            fill_in[0] = fill_ff[0] + CountW'(1);
            leaves_in  = leaves_ff + CountW'(1);
            order_in   = leaves_ff[PosW-1:0];
            lv_in      = '0;
         end
         imac_pkg::OP_INIT_VERIFY: begin
            order_in = PosW'(idx_ff);
            lv_in    = '0;
         end
         imac_pkg::OP_INIT_ROOT: lv_in = '0;
         imac_pkg::OP_SRCH_INIT: begin
            off_in = OffW'(order_ff) + OffW'(1);
            k_in   = lv_up;
         end
         imac_pkg::OP_SRCH_NEXT: begin
            off_in = off_ff << 1;
            k_in   = k_dn;
         end
         imac_pkg::OP_ADVANCE: begin
            order_in = order_ff >> 1;
            lv_in    = lv_up;
         end
         imac_pkg::OP_LEVEL_UP: lv_in = lv_up;
         imac_pkg::OP_STORE_PARENT: begin
            d_in     = hash_digest;
            if (CountW'(wr_pos) == fill_up) fill_in[lv_up] = fill_up + CountW'(1);
            order_in = order_ff >> 1;
            lv_in    = lv_up;
         end
         imac_pkg::OP_TAKE_HASH: begin
            d_in     = hash_digest;
            order_in = order_ff >> 1;
            lv_in    = lv_up;
         end
         imac_pkg::OP_COMPARE: begin
            status_in = (d_ff != other) ? imac_pkg::ST_MISMATCH : imac_pkg::ST_OK;
         end
         imac_pkg::OP_TAKE_ROOT: root_in = other;
         imac_pkg::OP_RSP_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_root_in   = root_ff;
            rsp_count_in  = leaves_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaves_ff    <= '0;
         fill_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         leaves_ff    <= leaves_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      d_ff          <= d_in;
      root_ff       <= root_in;
      status_ff     <= status_in;
      order_ff      <= order_in;
      lv_ff         <= lv_in;
      k_ff          <= k_in;
      off_ff        <= off_in;
      zero_ff       <= zero_in;
      rsp_status_ff <= rsp_status_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_count_ff  <= rsp_count_in;
   end

   imac_ram #(.Width(HashW), .Depth(imac_pkg::NodeCount)) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   imac_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .msg    (hash_msg),
      .busy   (hash_busy),
      .done   (hash_done),
      .digest (hash_digest)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.root_word0 = rsp_root_ff[255:192];
   assign rsp_ch.root_word1 = rsp_root_ff[191:128];
   assign rsp_ch.root_word2 = rsp_root_ff[127:64];
   assign rsp_ch.root_word3 = rsp_root_ff[63:0];
   assign rsp_ch.leaf_count = rsp_count_ff;

   always_comb begin
      flags.mode       = mode_ff;
      flags.full       = (leaves_ff >= CountW'(imac_pkg::Capacity));
      flags.idx_bad    = (CountW'(idx_ff) >= leaves_ff);
      flags.empty      = (leaves_ff == '0);
      flags.order_zero = (order_ff == '0);
      flags.order_odd  = order_ff[0];
      flags.lv_top     = lv_top;
      flags.has_next   = !lv_top && (fill_up != '0);
      flags.srch_hit   = (off_ff < OffW'(fill_k));
      flags.srch_stop  = (off_ff > imac_pkg::OffLimit) || (k_dn == '0);
      flags.hash_done  = hash_done;
      flags.rsp_busy   = rsp_valid_ff && !rsp_ch.ready;
   end

   a_leaf_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] == leaves_ff)
      else $error("level 0 fill count differs from leaf count");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      leaves_ff <= CountW'(imac_pkg::Capacity))
      else $error("leaf count beyond capacity");

   a_hash_free: assert property (@(posedge clock) disable iff (reset)
      hash_start |-> !hash_busy)
      else $error("hash started while busy");

endmodule

// ===== sv/imac_ctrl.sv =====
// imac_ctrl: sequencer for append, verify and root read transactions
// issues imac_pkg::cmd_type to imac_datapath and reads its flags

module imac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  imac_pkg::flags_type  flags,
   output imac_pkg::cmd_type    cmd,
   output logic                 req_ready
);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_DISPATCH = 14'b00000000000010,
      S_A_STEP   = 14'b00000000000100,
      S_A_RD     = 14'b00000000001000,
      S_A_HASH   = 14'b00000000010000,
      S_V_STEP   = 14'b00000000100000,
      S_V_RDL    = 14'b00000001000000,
      S_V_SRCH   = 14'b00000010000000,
      S_V_RDR    = 14'b00000100000000,
      S_V_HASH   = 14'b00001000000000,
      S_V_CMP    = 14'b00010000000000,
      S_R_STEP   = 14'b00100000000000,
      S_R_RD     = 14'b01000000000000,
      S_DONE     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = imac_pkg::OP_NONE;
      cmd.status = imac_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = imac_pkg::OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (flags.mode)
               imac_pkg::MODE_APPEND: begin
                  if (flags.full) begin
                     cmd.op     = imac_pkg::OP_SET_STATUS;
                     cmd.status = imac_pkg::ST_FULL;
                     state_in   = S_DONE;
                  end else begin
                     cmd.op   = imac_pkg::OP_APPEND_LEAF;
                     state_in = S_A_STEP;
                  end
               end
               imac_pkg::MODE_VERIFY: begin
                  if (flags.idx_bad) begin
                     cmd.op     = imac_pkg::OP_SET_STATUS;
                     cmd.status = imac_pkg::ST_BAD;
                     state_in   = S_DONE;
                  end else begin
                     cmd.op   = imac_pkg::OP_INIT_VERIFY;
                     state_in = S_V_STEP;
                  end
               end
               imac_pkg::MODE_ROOT: begin
                  if (flags.empty) begin
                     cmd.op     = imac_pkg::OP_SET_STATUS;
                     cmd.status = imac_pkg::ST_BAD;
                     state_in   = S_DONE;
                  end else begin
                     cmd.op   = imac_pkg::OP_INIT_ROOT;
                     state_in = S_R_STEP;
                  end
               end
               imac_pkg::MODE_NONE: begin
                  cmd.op     = imac_pkg::OP_SET_STATUS;
                  cmd.status = imac_pkg::ST_BAD;
                  state_in   = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         // append: combine with the stored left sibling wherever the node is a right child
         S_A_STEP: begin
            priority if (flags.order_zero || flags.lv_top) begin
               state_in = S_DONE;
            end else if (flags.order_odd) begin
               cmd.op   = imac_pkg::OP_READ_LEFT;
               state_in = S_A_RD;
            end else begin
               cmd.op = imac_pkg::OP_ADVANCE;
            end
         end
         S_A_RD: begin
            cmd.op   = imac_pkg::OP_HASH_LR;
            state_in = S_A_HASH;
         end
         S_A_HASH: begin
            if (flags.hash_done) begin
               cmd.op   = imac_pkg::OP_STORE_PARENT;
               state_in = S_A_STEP;
            end
         end
         S_V_STEP: begin
            priority if (!flags.has_next) begin
               cmd.op   = imac_pkg::OP_READ_SELF;
               state_in = S_V_CMP;
            end else if (flags.order_odd) begin
               cmd.op   = imac_pkg::OP_READ_LEFT;
               state_in = S_V_RDL;
            end else begin
               cmd.op   = imac_pkg::OP_SRCH_INIT;
               state_in = S_V_SRCH;
            end
         end
         S_V_RDL: begin
            cmd.op   = imac_pkg::OP_HASH_LR;
            state_in = S_V_HASH;
         end
         // left child: look for the right sibling at its own level, then level by level lower, position doubled
         S_V_SRCH: begin
            priority if (flags.srch_hit) begin
               cmd.op   = imac_pkg::OP_SRCH_READ;
               state_in = S_V_RDR;
            end else if (flags.srch_stop) begin
               cmd.op   = imac_pkg::OP_ADVANCE;
               state_in = S_V_STEP;
            end else begin
               cmd.op = imac_pkg::OP_SRCH_NEXT;
            end
         end
         S_V_RDR: begin
            cmd.op   = imac_pkg::OP_HASH_DR;
            state_in = S_V_HASH;
         end
         S_V_HASH: begin
            if (flags.hash_done) begin
               cmd.op   = imac_pkg::OP_TAKE_HASH;
               state_in = S_V_STEP;
            end
         end
         S_V_CMP: begin
            cmd.op   = imac_pkg::OP_COMPARE;
            state_in = S_DONE;
         end
         S_R_STEP: begin
            if (flags.has_next) begin
               cmd.op = imac_pkg::OP_LEVEL_UP;
            end else begin
               cmd.op   = imac_pkg::OP_READ_ROOT;
               state_in = S_R_RD;
            end
         end
         S_R_RD: begin
            cmd.op   = imac_pkg::OP_TAKE_ROOT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!flags.rsp_busy) begin
               cmd.op   = imac_pkg::OP_RSP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_hash_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_HASH && !flags.hash_done) |=> state_ff == S_A_HASH)
      else $error("append left hash wait early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && flags.rsp_busy) |-> cmd.op != imac_pkg::OP_RSP_LOAD)
      else $error("response register overwritten while stalled");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == imac_pkg::OP_CAPTURE) |=> state_ff == S_DISPATCH)
      else $error("captured transaction not dispatched");

endmodule

// ===== sv/incremental_merkle_accumulator.sv =====
// incremental merkle accumulator: one transaction at a time, result after it finishes
// node hash = four sha256 compressions in one shared hash unit
// append: up to one node hash per tree level, at most 10 of them
// verify: up to 10 node hashes plus a sibling search per level
// read root: the next request is taken once this one is done
// synchronous reset empties the tree at once; the node memory needs no clearing

module incremental_merkle_accumulator (
   input  logic        clock,
   input  logic        reset,
   imac_req_if.sink    req_ch,
   imac_rsp_if.source  rsp_ch
);

   imac_pkg::cmd_type   cmd;
   imac_pkg::flags_type flags;
   logic                ctl_ready;

   assign req_ch.ready = ctl_ready;

   imac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .flags     (flags),
      .cmd       (cmd),
      .req_ready (ctl_ready)
   );

   imac_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .flags  (flags)
   );

endmodule
